// ===== rtl/gpsf_pkg.sv =====
// Package for the current/GPS speed fusion block: shared widths, codes and types.
// Used by gpsf_cfg, gpsf_mul and current_gps_speed_fusion_unit; depends on nothing.
package gpsf_pkg;

	// Shared multiplier operand and product widths
	localparam int unsigned AW = 37;
	localparam int unsigned BW = 17;
	localparam int unsigned PW = AW + BW;

	// Configuration port widths
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Weights are Q1.8; 256 stands for one
	localparam int unsigned WGT_W = 9;
	localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

	// Register reset values
	localparam logic [15:0] GAIN_K_RST       = 16'd1966;
	localparam logic [15:0] TIME_STEP_RST    = 16'd6554;
	localparam logic [15:0] CUR_THRESH_RST   = 16'd5;
	localparam logic [WGT_W-1:0] ALPHA_BRK_RST = 9'd205;
	localparam logic [WGT_W-1:0] ALPHA_NRM_RST = 9'd77;
	localparam logic [WGT_W-1:0] BETA_RST      = 9'd51;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_K       = 3'd0,
		CFG_TIME_STEP    = 3'd1,
		CFG_CUR_THRESH   = 3'd2,
		CFG_ALPHA_BRAKE  = 3'd3,
		CFG_ALPHA_NORMAL = 3'd4,
		CFG_BETA_GAIN    = 3'd5
	} cfg_idx_t;

	// Register contents, weights already saturated to one
	typedef struct packed {
		logic        [15:0]      gain_k;
		logic        [15:0]      time_step;
		logic signed [15:0]      cur_limit;
		logic        [WGT_W-1:0] alpha_stop;
		logic        [WGT_W-1:0] alpha_cruise;
		logic        [WGT_W-1:0] beta_gain;
	} cfg_t;

	// Sequencer states
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_KDT  = 9'b000000010,
		ST_VEL  = 9'b000000100,
		ST_PRED = 9'b000001000,
		ST_CORR = 9'b000010000,
		ST_EST  = 9'b000100000,
		ST_FEST = 9'b001000000,
		ST_FGPS = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

endpackage

// ===== rtl/gpsf_cfg.sv =====
// Configuration register file for the speed fusion block.
// Depends on gpsf_pkg for the register indexes and the cfg_t struct.
module gpsf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [gpsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpsf_pkg::CFG_DATA_W-1:0] cfg_data,
	output gpsf_pkg::cfg_t                  cfg
);

	logic [15:0] gain_k_q;
	logic [15:0] time_step_q;
	logic [15:0] cur_thresh_q;
	logic [gpsf_pkg::WGT_W-1:0] alpha_brk_q;
	logic [gpsf_pkg::WGT_W-1:0] alpha_nrm_q;
	logic [gpsf_pkg::WGT_W-1:0] beta_q;

	// Update the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_k_q     <= gpsf_pkg::GAIN_K_RST;
			time_step_q  <= gpsf_pkg::TIME_STEP_RST;
			cur_thresh_q <= gpsf_pkg::CUR_THRESH_RST;
			alpha_brk_q  <= gpsf_pkg::ALPHA_BRK_RST;
			alpha_nrm_q  <= gpsf_pkg::ALPHA_NRM_RST;
			beta_q       <= gpsf_pkg::BETA_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gpsf_pkg::CFG_GAIN_K:       gain_k_q     <= cfg_data;
				gpsf_pkg::CFG_TIME_STEP:    time_step_q  <= cfg_data;
				gpsf_pkg::CFG_CUR_THRESH:   cur_thresh_q <= cfg_data;
				gpsf_pkg::CFG_ALPHA_BRAKE:  alpha_brk_q  <= cfg_data[gpsf_pkg::WGT_W-1:0];
				gpsf_pkg::CFG_ALPHA_NORMAL: alpha_nrm_q  <= cfg_data[gpsf_pkg::WGT_W-1:0];
				gpsf_pkg::CFG_BETA_GAIN:    beta_q       <= cfg_data[gpsf_pkg::WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate weights above one
	always_comb begin
		cfg.gain_k       = gain_k_q;
		cfg.time_step    = time_step_q;
		cfg.cur_limit    = $signed(cur_thresh_q);
		cfg.alpha_stop   = (alpha_brk_q > gpsf_pkg::WGT_ONE) ? gpsf_pkg::WGT_ONE : alpha_brk_q;
		cfg.alpha_cruise = (alpha_nrm_q > gpsf_pkg::WGT_ONE) ? gpsf_pkg::WGT_ONE : alpha_nrm_q;
		cfg.beta_gain    = (beta_q > gpsf_pkg::WGT_ONE) ? gpsf_pkg::WGT_ONE : beta_q;
	end

endmodule

// ===== rtl/gpsf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on gpsf_pkg for the operand and product widths.
module gpsf_mul (
	input  logic                              clk,
	input  logic signed [gpsf_pkg::AW-1:0]    a,
	input  logic signed [gpsf_pkg::BW-1:0]    b,
	output logic signed [gpsf_pkg::PW-1:0]    p_q
);

	// Register the product every cycle
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/current_gps_speed_fusion_unit.sv =====
// Current/GPS speed fusion: complementary filter on one shared multiplier.
// After the input beat is taken the sequencer steps through KDT, VEL, PRED, CORR,
// EST, FEST, FGPS and OUT, with five passes through the multiplier plus add steps;
// a new sample is taken only in IDLE, and a stalled result holds the sequencer in OUT.
// Reset clears the speed estimate, the sequencer and loads the register defaults.
// Depends on gpsf_pkg, gpsf_cfg and gpsf_mul.
module current_gps_speed_fusion_unit #(
	parameter int unsigned SPEED_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                motor_current,
	input  logic        [15:0]                gnss_speed,
	input  logic                              brake_pedal,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic        [7:0]                 display_speed,
	input  logic                              cfg_write,
	input  logic [gpsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned AW = gpsf_pkg::AW;
	localparam int unsigned BW = gpsf_pkg::BW;
	localparam int unsigned PW = gpsf_pkg::PW;
	localparam int unsigned WW = gpsf_pkg::WGT_W;
	localparam int unsigned F  = SPEED_FRAC_BITS;

	// Rounding shifts: velocity step, beta correction, fused output
	localparam int unsigned VEL_SH = 32 - F;
	localparam int unsigned COR_SH = 8;
	localparam int unsigned FUS_SH = F + 8;
	localparam logic signed [PW-1:0] VEL_HALF = PW'(1) << (VEL_SH - 1);
	localparam logic signed [PW-1:0] COR_HALF = PW'(1) << (COR_SH - 1);
	localparam logic signed [PW-1:0] FUS_HALF = PW'(1) << (FUS_SH - 1);

	gpsf_pkg::cfg_t   cfg;
	gpsf_pkg::state_t state_q;

	logic signed [15:0]   cur_q;
	logic        [15:0]   gps_q;
	logic        [WW-1:0] alpha_q;
	logic        [WW-1:0] beta_q;
	logic        [31:0]   estimate_q;
	logic signed [AW-1:0] pred_q;
	logic signed [AW-1:0] est_new_q;
	logic signed [PW-1:0] acc_q;
	logic                 out_valid_q;
	logic        [7:0]    display_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] p_q;
	logic signed [AW-1:0] gps_ext;
	logic signed [PW-1:0] vel_sum;
	logic signed [PW-1:0] vel_rnd;
	logic signed [PW-1:0] cor_sum;
	logic signed [PW-1:0] cor_rnd;
	logic signed [PW-1:0] fus_sum;
	logic signed [PW-1:0] fus_rnd;
	logic                 braking;
	logic                 in_fire;
	logic                 out_free;

	gpsf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gpsf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign in_ready  = (state_q == gpsf_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign display_speed = display_q;
	assign braking   = (motor_current > cfg.cur_limit) || brake_pedal;

	// GPS speed in Q.F, widened to the operand width
	assign gps_ext = $signed({{(AW - 16 - F){1'b0}}, gps_q, {F{1'b0}}});

	// Round half up by adding half an LSB, then arithmetic shift
	assign vel_sum = p_q + VEL_HALF;
	assign vel_rnd = vel_sum >>> VEL_SH;
	assign cor_sum = p_q + COR_HALF;
	assign cor_rnd = cor_sum >>> COR_SH;
	assign fus_sum = acc_q + p_q + FUS_HALF;
	assign fus_rnd = fus_sum >>> FUS_SH;

	// Steer the shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			gpsf_pkg::ST_KDT: begin
				mul_a = $signed({{(AW - 16){1'b0}}, cfg.gain_k});
				mul_b = $signed({{(BW - 16){1'b0}}, cfg.time_step});
			end
			gpsf_pkg::ST_VEL: begin
				mul_a = $signed({{(AW - 32){1'b0}}, p_q[31:0]});
				mul_b = $signed({{(BW - 16){cur_q[15]}}, cur_q});
			end
			gpsf_pkg::ST_CORR: begin
				mul_a = gps_ext - pred_q;
				mul_b = $signed({{(BW - WW){1'b0}}, beta_q});
			end
			gpsf_pkg::ST_FEST: begin
				mul_a = est_new_q;
				mul_b = $signed({{(BW - WW){1'b0}}, alpha_q});
			end
			// Hold the GPS term on the product while the result waits
			gpsf_pkg::ST_FGPS, gpsf_pkg::ST_OUT: begin
				mul_a = gps_ext;
				mul_b = $signed({{(BW - WW){1'b0}}, gpsf_pkg::WGT_ONE - alpha_q});
			end
			default: ;
		endcase
	end

	// Advance the sequencer and hold the estimate and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gpsf_pkg::ST_IDLE;
			estimate_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == gpsf_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				gpsf_pkg::ST_IDLE: if (in_fire) state_q <= gpsf_pkg::ST_KDT;
				gpsf_pkg::ST_KDT:  state_q <= gpsf_pkg::ST_VEL;
				gpsf_pkg::ST_VEL:  state_q <= gpsf_pkg::ST_PRED;
				gpsf_pkg::ST_PRED: state_q <= gpsf_pkg::ST_CORR;
				gpsf_pkg::ST_CORR: state_q <= gpsf_pkg::ST_EST;
				gpsf_pkg::ST_EST:  state_q <= gpsf_pkg::ST_FEST;
				gpsf_pkg::ST_FEST: state_q <= gpsf_pkg::ST_FGPS;
				gpsf_pkg::ST_FGPS: state_q <= gpsf_pkg::ST_OUT;
				gpsf_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= gpsf_pkg::ST_IDLE;
						// Clamp the stored estimate to 0..2^32-1
						if (est_new_q < 0) begin
							estimate_q <= '0;
						end else if (est_new_q[AW-1:32] != '0) begin
							estimate_q <= '1;
						end else begin
							estimate_q <= est_new_q[31:0];
						end
					end
				end
				default: state_q <= gpsf_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_q   <= motor_current;
			gps_q   <= gnss_speed;
			alpha_q <= braking ? cfg.alpha_stop : cfg.alpha_cruise;
			beta_q  <= cfg.beta_gain;
		end
		if (state_q == gpsf_pkg::ST_PRED) begin
			pred_q <= $signed({{(AW - 32){1'b0}}, estimate_q}) + vel_rnd[AW-1:0];
		end
		if (state_q == gpsf_pkg::ST_EST) begin
			est_new_q <= pred_q + cor_rnd[AW-1:0];
		end
		if (state_q == gpsf_pkg::ST_FGPS) begin
			acc_q <= p_q;
		end
		// Saturate the fused speed to 0..255
		if (state_q == gpsf_pkg::ST_OUT && out_free) begin
			if (fus_rnd < 0) begin
				display_q <= '0;
			end else if (fus_rnd[PW-1:8] != '0) begin
				display_q <= '1;
			end else begin
				display_q <= fus_rnd[7:0];
			end
		end
	end

endmodule
